>>> rtl/core/lav_pkg.sv
package lav_pkg;

   // Word format of every coordinate and matrix entry.
   localparam int WORD_W        = 32;
   localparam int LAV_FRAC_BITS = 16;

   // Normalization scales the largest magnitude into [2^NORM_TOP, 2^(NORM_TOP+1)).
   localparam int NORM_TOP = 29;
   localparam int NORM_W   = NORM_TOP + 1;

   // Row codes of the emitted matrix.
   localparam logic [1:0] ROW_X = 2'd0;
   localparam logic [1:0] ROW_Y = 2'd1;
   localparam logic [1:0] ROW_Z = 2'd2;
   localparam logic [1:0] ROW_H = 2'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] eye_x;
      logic signed [WORD_W-1:0] eye_y;
      logic signed [WORD_W-1:0] eye_z;
      logic signed [WORD_W-1:0] target_x;
      logic signed [WORD_W-1:0] target_y;
      logic signed [WORD_W-1:0] target_z;
      logic signed [WORD_W-1:0] up_x;
      logic signed [WORD_W-1:0] up_y;
      logic signed [WORD_W-1:0] up_z;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]               row_index;
      logic signed [WORD_W-1:0] col_0;
      logic signed [WORD_W-1:0] col_1;
      logic signed [WORD_W-1:0] col_2;
      logic signed [WORD_W-1:0] col_3;
      logic                     degenerate;
      logic                     last_row;
   } rsp_payload_type;

endpackage

>>> rtl/core/lav_req_if.sv
interface lav_req_if;
   import lav_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/lav_rsp_if.sv
interface lav_rsp_if;
   import lav_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/lav_norm.sv
module lav_norm #(
   parameter int MAG_W     = 33,
   parameter int SIDE_W    = 1,
   parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic [2:0][MAG_W-1:0]                in_mag,
   input  logic [2:0]                           in_neg,
   input  logic [SIDE_W-1:0]                    in_side,
   output logic                                 out_valid,
   output logic [2:0][lav_pkg::WORD_W-1:0]      out_unit,
   output logic                                 out_zero,
   output logic [SIDE_W-1:0]                    out_side
);
   import lav_pkg::*;

   localparam int JS         = $clog2(MAG_W);
   localparam int SQ_W       = 2 * NORM_W;
   localparam int ACC_W      = SQ_W + 2;
   localparam int ROOT_STEPS = ACC_W / 2;
   localparam int LEN_W      = ROOT_STEPS;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int DIV_W      = NORM_W + FRAC_BITS + 2;

   // Left-justify stages.
   logic                    jv_ff [JS+1];
   logic [2:0][MAG_W-1:0]   jm_ff [JS+1];
   logic [2:0]              jn_ff [JS+1];
   logic [SIDE_W-1:0]       js_ff [JS+1];

   // Square stage.
   logic                    qv_ff;
   logic [SQ_W-1:0]         qsq_ff [3];
   logic [2:0][NORM_W-1:0]  qm_ff;
   logic [2:0]              qn_ff;
   logic                    qz_ff;
   logic [SIDE_W-1:0]       qs_ff;

   // Square root stages.
   logic                    rv_ff [ROOT_STEPS+1];
   logic [ACC_W-1:0]        rn_ff [ROOT_STEPS];
   logic [ACC_W-1:0]        rr_ff [ROOT_STEPS+1];
   logic [2:0][NORM_W-1:0]  rm_ff [ROOT_STEPS+1];
   logic [2:0]              rneg_ff [ROOT_STEPS+1];
   logic                    rz_ff [ROOT_STEPS+1];
   logic [SIDE_W-1:0]       rs_ff [ROOT_STEPS+1];

   // Division stages.
   logic                    dv_ff [QUO_W+1];
   logic [2:0][DIV_W-1:0]   drem_ff [QUO_W];
   logic [LEN_W-1:0]        dlen_ff [QUO_W];
   logic [2:0][QUO_W-1:0]   dq_ff [QUO_W+1];
   logic [2:0]              dneg_ff [QUO_W+1];
   logic                    dz_ff [QUO_W+1];
   logic [SIDE_W-1:0]       ds_ff [QUO_W+1];

   // Output stage.
   logic                    ov_ff;
   logic [2:0][WORD_W-1:0]  ou_ff;
   logic [2:0][WORD_W-1:0]  ou_in;
   logic                    oz_ff;
   logic [SIDE_W-1:0]       os_ff;

   logic [2:0][NORM_W-1:0]  top_m;
   logic [2:0][DIV_W-1:0]   drem_in;
   logic [WORD_W-1:0]       mag_word [3];

   // Capture the incoming transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         jv_ff[0] <= 1'b0;
      end else if (adv) begin
         jv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         jm_ff[0] <= in_mag;
         jn_ff[0] <= in_neg;
         js_ff[0] <= in_side;
      end
   end

   // Left-justify the three magnitudes together, one power-of-two shift per stage.
   for (genvar k = 0; k < JS; k++) begin : g_just
      localparam int SH = 1 << (JS - 1 - k);
      logic [MAG_W-1:0]      all_or;
      logic [2:0][MAG_W-1:0] m_in;

      always_comb begin
         all_or = jm_ff[k][0] | jm_ff[k][1] | jm_ff[k][2];
         m_in   = jm_ff[k];
         if (all_or[MAG_W-1 -: SH] == '0) begin
            for (int i = 0; i < 3; i++) begin
               m_in[i] = jm_ff[k][i] << SH;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            jv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            jv_ff[k+1] <= jv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            jm_ff[k+1] <= m_in;
            jn_ff[k+1] <= jn_ff[k];
            js_ff[k+1] <= js_ff[k];
         end
      end
   end

   // The top bits of the justified word are the scaled magnitudes.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         top_m[i] = jm_ff[JS][i][MAG_W-1 -: NORM_W];
      end
   end

   // Square each scaled component.
   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 1'b0;
      end else if (adv) begin
         qv_ff <= jv_ff[JS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            qsq_ff[i] <= SQ_W'(top_m[i]) * SQ_W'(top_m[i]);
         end
         qm_ff <= top_m;
         qn_ff <= jn_ff[JS];
         qz_ff <= ~(top_m[0][NORM_W-1] | top_m[1][NORM_W-1] | top_m[2][NORM_W-1]);
         qs_ff <= js_ff[JS];
      end
   end

   // Sum of squares seeds the square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (adv) begin
         rv_ff[0] <= qv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rn_ff[0]   <= ACC_W'(qsq_ff[0]) + ACC_W'(qsq_ff[1]) + ACC_W'(qsq_ff[2]);
         rr_ff[0]   <= '0;
         rm_ff[0]   <= qm_ff;
         rneg_ff[0] <= qn_ff;
         rz_ff[0]   <= qz_ff;
         rs_ff[0]   <= qs_ff;
      end
   end

   // Integer square root, one result bit per stage.
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [ACC_W-1:0] RBIT = ACC_W'(1) << (ACC_W - 2 - 2 * k);
      logic [ACC_W:0]   trial;
      logic             fits;
      logic [ACC_W-1:0] r_in;

      always_comb begin
         trial = {1'b0, rr_ff[k]} + {1'b0, RBIT};
         fits  = {1'b0, rn_ff[k]} >= trial;
         r_in  = fits ? (rr_ff[k] >> 1) + RBIT : rr_ff[k] >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            rv_ff[k+1] <= rv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rr_ff[k+1]   <= r_in;
            rm_ff[k+1]   <= rm_ff[k];
            rneg_ff[k+1] <= rneg_ff[k];
            rz_ff[k+1]   <= rz_ff[k];
            rs_ff[k+1]   <= rs_ff[k];
         end
      end

      if (k < ROOT_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rn_ff[k+1] <= fits ? rn_ff[k] - trial[ACC_W-1:0] : rn_ff[k];
            end
         end
      end
   end

   // Dividends carry half the length for round to nearest.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         drem_in[i] = (DIV_W'(rm_ff[ROOT_STEPS][i]) << FRAC_BITS)
                    + DIV_W'(rr_ff[ROOT_STEPS][LEN_W-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= rv_ff[ROOT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drem_ff[0] <= drem_in;
         dlen_ff[0] <= rr_ff[ROOT_STEPS][LEN_W-1:0];
         dq_ff[0]   <= '0;
         dneg_ff[0] <= rneg_ff[ROOT_STEPS];
         dz_ff[0]   <= rz_ff[ROOT_STEPS];
         ds_ff[0]   <= rs_ff[ROOT_STEPS];
      end
   end

   // Restoring division of the three components, one quotient bit per stage.
   for (genvar t = 0; t < QUO_W; t++) begin : g_div
      localparam int SH = QUO_W - 1 - t;
      logic [DIV_W-1:0]      dsor;
      logic [2:0][DIV_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0] q_in;

      always_comb begin
         dsor   = DIV_W'(dlen_ff[t]) << SH;
         rem_in = drem_ff[t];
         q_in   = dq_ff[t];
         for (int i = 0; i < 3; i++) begin
            if (drem_ff[t][i] >= dsor) begin
               rem_in[i]   = drem_ff[t][i] - dsor;
               q_in[i][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[t+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[t+1] <= dv_ff[t];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dq_ff[t+1]   <= q_in;
            dneg_ff[t+1] <= dneg_ff[t];
            dz_ff[t+1]   <= dz_ff[t];
            ds_ff[t+1]   <= ds_ff[t];
         end
      end

      if (t < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               drem_ff[t+1] <= rem_in;
               dlen_ff[t+1] <= dlen_ff[t];
            end
         end
      end
   end

   // Restore the signs; a zero vector gives a zero unit vector.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_word[i] = WORD_W'(dq_ff[QUO_W][i]);
         if (dz_ff[QUO_W]) begin
            ou_in[i] = '0;
         end else if (dneg_ff[QUO_W][i]) begin
            ou_in[i] = '0 - mag_word[i];
         end else begin
            ou_in[i] = mag_word[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= dv_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ou_ff <= ou_in;
         oz_ff <= dz_ff[QUO_W];
         os_ff <= ds_ff[QUO_W];
      end
   end

   assign out_valid = ov_ff;
   assign out_unit  = ou_ff;
   assign out_zero  = oz_ff;
   assign out_side  = os_ff;

endmodule

>>> rtl/core/look_at_view_matrix_core.sv
// Channel  Dir  Handshake      Carries
// req_ch   in   valid/ready    eye, target and up vectors, signed fixed point
// rsp_ch   out  valid/ready    one matrix row per transaction, rows 0 to 3
//
// Every transaction enters a single pipeline of 2*FRAC_BITS + 94 stages (two
// normalizers with a 31-step square root and a FRAC_BITS+1 step divider each,
// plus cross product, y axis and translation stages). The row serializer at the
// end sends four rows, taking the next transaction as its last row is sent. Reset
// clears the valid bits and row index. An rsp_ch stall halts a pipeline whose end is full.
module look_at_view_matrix_core #(
   parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
   input  logic     clock,
   input  logic     reset,
   lav_req_if.sink   req_ch,
   lav_rsp_if.source rsp_ch
);
   import lav_pkg::*;

   localparam int EYE_SIDE_W = 6 * WORD_W;
   localparam int Z_SIDE_W   = 6 * WORD_W + 1;
   localparam logic [63:0] ROUND_HALF = 64'(1) << (FRAC_BITS - 1);
   localparam logic [63:0] SAT_POS    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] SAT_NEG    = 64'h0000_0000_8000_0000;
   localparam logic [WORD_W-1:0] ONE_WORD = WORD_W'(1) << FRAC_BITS;

   // Round to nearest with ties away from zero, then saturate to one word.
   function automatic logic [WORD_W-1:0] round_sat(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + ROUND_HALF) >> FRAC_BITS;
      if (v[63]) begin
         round_sat = (r > SAT_NEG) ? SAT_NEG[WORD_W-1:0] : WORD_W'(~r + 64'd1);
      end else begin
         round_sat = (r > SAT_POS) ? SAT_POS[WORD_W-1:0] : r[WORD_W-1:0];
      end
   endfunction

   logic adv;
   logic rsp_fire;
   logic sr_take;

   // Input vectors and eye minus target.
   logic [2:0][WORD_W-1:0] in_eye;
   logic [2:0][WORD_W-1:0] in_tgt;
   logic [2:0][WORD_W-1:0] in_up;
   logic [WORD_W:0]        dif [3];
   logic [2:0][WORD_W:0]   dif_mag;
   logic [2:0]             dif_neg;

   // First normalizer (z axis).
   logic                   n1_v;
   logic [2:0][WORD_W-1:0] n1_z;
   logic                   n1_zero;
   logic [EYE_SIDE_W-1:0]  n1_side;
   logic [2:0][WORD_W-1:0] n1_eye;
   logic [2:0][WORD_W-1:0] n1_up;

   // Cross product up x z.
   logic                   c1_v_ff;
   logic signed [63:0]     c1_p_ff [6];
   logic [2:0][WORD_W-1:0] c1_z_ff;
   logic [2:0][WORD_W-1:0] c1_eye_ff;
   logic                   c1_deg_ff;
   logic                   c2_v_ff;
   logic signed [63:0]     c2_c_ff [3];
   logic [2:0][WORD_W-1:0] c2_z_ff;
   logic [2:0][WORD_W-1:0] c2_eye_ff;
   logic                   c2_deg_ff;
   logic [63:0]            c_abs [3];
   logic [2:0][62:0]       c_mag;
   logic [2:0]             c_neg;

   // Second normalizer (x axis).
   logic                   n2_v;
   logic [2:0][WORD_W-1:0] n2_x;
   logic                   n2_zero;
   logic [Z_SIDE_W-1:0]    n2_side;
   logic [2:0][WORD_W-1:0] n2_eye;
   logic [2:0][WORD_W-1:0] n2_z;
   logic                   n2_deg;

   // y = z x x.
   logic                   y1_v_ff;
   logic signed [63:0]     y1_p_ff [6];
   logic [2:0][WORD_W-1:0] y1_x_ff;
   logic [2:0][WORD_W-1:0] y1_z_ff;
   logic [2:0][WORD_W-1:0] y1_eye_ff;
   logic                   y1_deg_ff;
   logic                   y2_v_ff;
   logic signed [63:0]     y2_d_ff [3];
   logic [2:0][WORD_W-1:0] y2_x_ff;
   logic [2:0][WORD_W-1:0] y2_z_ff;
   logic [2:0][WORD_W-1:0] y2_eye_ff;
   logic                   y2_deg_ff;
   logic                   y3_v_ff;
   logic [2:0][WORD_W-1:0] y3_y_ff;
   logic [2:0][WORD_W-1:0] y3_x_ff;
   logic [2:0][WORD_W-1:0] y3_z_ff;
   logic [2:0][WORD_W-1:0] y3_eye_ff;
   logic                   y3_deg_ff;
   logic [2:0][WORD_W-1:0] y3_ax [3];

   // Translations.
   logic                   t1_v_ff;
   logic signed [63:0]     t1_p_ff [9];
   logic [2:0][WORD_W-1:0] t1_ax_ff [3];
   logic                   t1_deg_ff;
   logic                   t2_v_ff;
   logic signed [63:0]     t2_dot_ff [3];
   logic [2:0][WORD_W-1:0] t2_ax_ff [3];
   logic                   t2_deg_ff;
   logic                   t3_v_ff;
   logic [WORD_W-1:0]      t3_t_ff [3];
   logic [2:0][WORD_W-1:0] t3_ax_ff [3];
   logic                   t3_deg_ff;

   // Row serializer.
   logic                   sr_v_ff;
   logic [1:0]             sr_row_ff;
   logic [WORD_W-1:0]      sr_t_ff [3];
   logic [2:0][WORD_W-1:0] sr_ax_ff [3];
   logic                   sr_deg_ff;

   // The pipeline moves whenever its last stage is empty or the serializer takes it.
   assign rsp_fire = sr_v_ff & rsp_ch.ready;
   assign sr_take  = ~sr_v_ff | (rsp_fire & (sr_row_ff == ROW_H));
   assign adv      = ~t3_v_ff | sr_take;
   assign req_ch.ready = adv;

   // Gather the input transaction and form eye minus target.
   always_comb begin
      in_eye = {req_ch.payload.eye_z, req_ch.payload.eye_y, req_ch.payload.eye_x};
      in_tgt = {req_ch.payload.target_z, req_ch.payload.target_y,
                req_ch.payload.target_x};
      in_up  = {req_ch.payload.up_z, req_ch.payload.up_y, req_ch.payload.up_x};
      for (int i = 0; i < 3; i++) begin
         dif[i]     = {in_eye[i][WORD_W-1], in_eye[i]} - {in_tgt[i][WORD_W-1], in_tgt[i]};
         dif_neg[i] = dif[i][WORD_W];
         dif_mag[i] = dif_neg[i] ? '0 - dif[i] : dif[i];
      end
   end

   lav_norm #(
      .MAG_W     (WORD_W + 1),
      .SIDE_W    (EYE_SIDE_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_mag    (dif_mag),
      .in_neg    (dif_neg),
      .in_side   ({in_eye, in_up}),
      .out_valid (n1_v),
      .out_unit  (n1_z),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   assign {n1_eye, n1_up} = n1_side;

   // Valid bits of the stages after the first normalizer.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         y1_v_ff <= 1'b0;
         y2_v_ff <= 1'b0;
         y3_v_ff <= 1'b0;
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
      end else if (adv) begin
         c1_v_ff <= n1_v;
         c2_v_ff <= c1_v_ff;
         y1_v_ff <= n2_v;
         y2_v_ff <= y1_v_ff;
         y3_v_ff <= y2_v_ff;
         t1_v_ff <= y3_v_ff;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
      end
   end

   // Cross product up x z: products, then differences.
   always_ff @(posedge clock) begin
      if (adv) begin
         c1_p_ff[0] <= $signed(n1_up[1]) * $signed(n1_z[2]);
         c1_p_ff[1] <= $signed(n1_up[2]) * $signed(n1_z[1]);
         c1_p_ff[2] <= $signed(n1_up[2]) * $signed(n1_z[0]);
         c1_p_ff[3] <= $signed(n1_up[0]) * $signed(n1_z[2]);
         c1_p_ff[4] <= $signed(n1_up[0]) * $signed(n1_z[1]);
         c1_p_ff[5] <= $signed(n1_up[1]) * $signed(n1_z[0]);
         c1_z_ff    <= n1_z;
         c1_eye_ff  <= n1_eye;
         c1_deg_ff  <= n1_zero;

         c2_c_ff[0] <= c1_p_ff[0] - c1_p_ff[1];
         c2_c_ff[1] <= c1_p_ff[2] - c1_p_ff[3];
         c2_c_ff[2] <= c1_p_ff[4] - c1_p_ff[5];
         c2_z_ff    <= c1_z_ff;
         c2_eye_ff  <= c1_eye_ff;
         c2_deg_ff  <= c1_deg_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_neg[i] = c2_c_ff[i][63];
         c_abs[i] = c_neg[i] ? 64'(-c2_c_ff[i]) : 64'(c2_c_ff[i]);
         c_mag[i] = c_abs[i][62:0];
      end
   end

   lav_norm #(
      .MAG_W     (63),
      .SIDE_W    (Z_SIDE_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c2_v_ff),
      .in_mag    (c_mag),
      .in_neg    (c_neg),
      .in_side   ({c2_eye_ff, c2_z_ff, c2_deg_ff}),
      .out_valid (n2_v),
      .out_unit  (n2_x),
      .out_zero  (n2_zero),
      .out_side  (n2_side)
   );

   assign {n2_eye, n2_z, n2_deg} = n2_side;

   // y = z x x: products, differences, rounding.
   always_ff @(posedge clock) begin
      if (adv) begin
         y1_p_ff[0] <= $signed(n2_z[1]) * $signed(n2_x[2]);
         y1_p_ff[1] <= $signed(n2_z[2]) * $signed(n2_x[1]);
         y1_p_ff[2] <= $signed(n2_z[2]) * $signed(n2_x[0]);
         y1_p_ff[3] <= $signed(n2_z[0]) * $signed(n2_x[2]);
         y1_p_ff[4] <= $signed(n2_z[0]) * $signed(n2_x[1]);
         y1_p_ff[5] <= $signed(n2_z[1]) * $signed(n2_x[0]);
         y1_x_ff    <= n2_x;
         y1_z_ff    <= n2_z;
         y1_eye_ff  <= n2_eye;
         y1_deg_ff  <= n2_deg | n2_zero;

         y2_d_ff[0] <= y1_p_ff[0] - y1_p_ff[1];
         y2_d_ff[1] <= y1_p_ff[2] - y1_p_ff[3];
         y2_d_ff[2] <= y1_p_ff[4] - y1_p_ff[5];
         y2_x_ff    <= y1_x_ff;
         y2_z_ff    <= y1_z_ff;
         y2_eye_ff  <= y1_eye_ff;
         y2_deg_ff  <= y1_deg_ff;

         for (int i = 0; i < 3; i++) begin
            y3_y_ff[i] <= round_sat(y2_d_ff[i]);
         end
         y3_x_ff   <= y2_x_ff;
         y3_z_ff   <= y2_z_ff;
         y3_eye_ff <= y2_eye_ff;
         y3_deg_ff <= y2_deg_ff;
      end
   end

   always_comb begin
      y3_ax[0] = y3_x_ff;
      y3_ax[1] = y3_y_ff;
      y3_ax[2] = y3_z_ff;
   end

   // Translations: axis times eye, dot sums, then rounding of the negated dot.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               t1_p_ff[3*r+i] <= $signed(y3_ax[r][i]) * $signed(y3_eye_ff[i]);
            end
            t1_ax_ff[r]  <= y3_ax[r];
            t2_dot_ff[r] <= t1_p_ff[3*r] + t1_p_ff[3*r+1] + t1_p_ff[3*r+2];
            t2_ax_ff[r]  <= t1_ax_ff[r];
            t3_t_ff[r]   <= round_sat(-t2_dot_ff[r]);
            t3_ax_ff[r]  <= t2_ax_ff[r];
         end
         t1_deg_ff <= y3_deg_ff;
         t2_deg_ff <= t1_deg_ff;
         t3_deg_ff <= t2_deg_ff;
      end
   end

   // Row serializer: holds one finished matrix and sends it row by row.
   always_ff @(posedge clock) begin
      if (reset) begin
         sr_v_ff   <= 1'b0;
         sr_row_ff <= ROW_X;
      end else if (t3_v_ff && sr_take) begin
         sr_v_ff   <= 1'b1;
         sr_row_ff <= ROW_X;
      end else if (rsp_fire) begin
         if (sr_row_ff == ROW_H) begin
            sr_v_ff <= 1'b0;
         end
         sr_row_ff <= sr_row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (t3_v_ff && sr_take) begin
         sr_t_ff   <= t3_t_ff;
         sr_ax_ff  <= t3_ax_ff;
         sr_deg_ff <= t3_deg_ff;
      end
   end

   // Select the row being sent.
   assign rsp_ch.valid = sr_v_ff;

   always_comb begin
      rsp_ch.payload.row_index  = sr_row_ff;
      rsp_ch.payload.degenerate = sr_deg_ff;
      rsp_ch.payload.last_row   = (sr_row_ff == ROW_H);
      case (sr_row_ff)
         ROW_X: begin
            rsp_ch.payload.col_0 = sr_ax_ff[0][0];
            rsp_ch.payload.col_1 = sr_ax_ff[0][1];
            rsp_ch.payload.col_2 = sr_ax_ff[0][2];
            rsp_ch.payload.col_3 = sr_t_ff[0];
         end
         ROW_Y: begin
            rsp_ch.payload.col_0 = sr_ax_ff[1][0];
            rsp_ch.payload.col_1 = sr_ax_ff[1][1];
            rsp_ch.payload.col_2 = sr_ax_ff[1][2];
            rsp_ch.payload.col_3 = sr_t_ff[1];
         end
         ROW_Z: begin
            rsp_ch.payload.col_0 = sr_ax_ff[2][0];
            rsp_ch.payload.col_1 = sr_ax_ff[2][1];
            rsp_ch.payload.col_2 = sr_ax_ff[2][2];
            rsp_ch.payload.col_3 = sr_t_ff[2];
         end
         default: begin
            rsp_ch.payload.col_0 = '0;
            rsp_ch.payload.col_1 = '0;
            rsp_ch.payload.col_2 = '0;
            rsp_ch.payload.col_3 = ONE_WORD;
         end
      endcase
   end

endmodule
